// ===== sv/cwob_pkg.sv =====
// Shared constants, codes and command/status types for the clipped write-once blitter.
package cwob_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS = 8;

    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 8;
    localparam int FRAME_W    = 9;
    localparam int SRC_W      = 11;
    localparam int OFF_W      = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 11;
    localparam int POS_W      = 13;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [SRC_W-1:0] SRC_W_TOP = 11'd1024;
    localparam logic [ROW_W-1:0] ROW_TOP   = 11'd2047;

    localparam logic [REQ_W-1:0] REQ_BLIT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd4;

    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [SRC_W-1:0]   RST_SOURCE_WIDTH = 11'd1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               last_pixel;
        logic [COORD_W-1:0] read_x;
        logic [COORD_W-1:0] read_y;
    } req_item_t;

    typedef struct packed {
        logic capture;   // take the input beat
        logic place;     // clip, form address, read the stores
        logic finish;    // blit: write the pixel if it is free
        logic load_out;  // read: load the result register
        logic sweep;     // clear one mask entry
    } cwob_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic             sweep_done;
    } cwob_stat_t;

endpackage

// ===== sv/cwob_if.sv =====
// Channel interfaces: request, response and configuration write.
interface cwob_req_if import cwob_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               last_pixel;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;

    modport source (output valid, req_type, red, green, blue, last_pixel, read_x, read_y,
                    input ready);
    modport sink (input valid, req_type, red, green, blue, last_pixel, read_x, read_y,
                  output ready);
endinterface

interface cwob_rsp_if import cwob_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              pixel_written;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;

    modport source (output valid, pixel_written, out_red, out_green, out_blue, input ready);
    modport sink (input valid, pixel_written, out_red, out_green, out_blue, output ready);
endinterface

interface cwob_cfg_if import cwob_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/cwob_ctrl.sv =====
// Controller state machine: sequences accept, address, decide and the mask sweep.
module cwob_ctrl import cwob_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [REQ_W-1:0] in_type,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  cwob_stat_t       stat,
    output cwob_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_PLACE  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.capture = accept;
                if (accept)
                begin
                    if (in_type == REQ_BLIT || in_type == REQ_READ)
                    begin
                        state_next = S_PLACE;
                    end
                    else if (in_type == REQ_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.kind == REQ_BLIT)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    // hold the read result until the output register frees up
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/cwob_dp.sv =====
// Datapath: configuration, source counters, clipping, mask and color memories, result register.
module cwob_dp import cwob_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cwob_cmd_t             cmd,
    output cwob_stat_t            stat,
    input  req_item_t             item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  pixel_written,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_blue
);

    localparam int PIX      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int LAST_PIX = PIX - 1;
    localparam int CB       = (COLOR_BITS > CHAN_W) ? CHAN_W : COLOR_BITS;
    localparam int CW       = 3 * CB;
    localparam logic [POS_W-1:0] MW = POS_W'(MAX_WIDTH);
    localparam logic [POS_W-1:0] MH = POS_W'(MAX_HEIGHT);

    // configuration
    logic [FRAME_W-1:0] frame_w_reg;
    logic [FRAME_W-1:0] frame_h_reg;
    logic [SRC_W-1:0]   src_w_reg;
    logic [OFF_W-1:0]   off_x_reg;
    logic [OFF_W-1:0]   off_y_reg;

    // source position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SRC_W-1:0] src_w_eff;

    // captured item
    logic [REQ_W-1:0] kind_reg;
    logic [POS_W-1:0] dx_reg, dy_reg;
    logic [CW-1:0]    color_reg;

    // placement and memory read
    logic [POS_W-1:0] eff_w, eff_h;
    logic             pos_ok;
    logic [AW-1:0]    place_addr;
    logic             inside_reg;
    logic [AW-1:0]    addr_reg;
    logic             mask_q;
    logic [CW-1:0]    color_q;
    logic             blit_hit;
    logic             hit_read;

    // sweep
    logic [AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic          sweep_done;

    // memories
    logic          mask_mem [PIX];
    logic [CW-1:0] color_mem [PIX];
    logic          mask_we;
    logic [AW-1:0] mask_wa;
    logic          mask_wd;
    logic          color_we;

    // result register
    logic              rsp_written_reg;
    logic [CHAN_W-1:0] rsp_red_reg, rsp_green_reg, rsp_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= RST_FRAME_WIDTH;
            frame_h_reg <= RST_FRAME_HEIGHT;
            src_w_reg   <= RST_SOURCE_WIDTH;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_w_reg <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: frame_h_reg <= cfg_data[FRAME_W-1:0];
                CFG_SOURCE_WIDTH: src_w_reg   <= cfg_data[SRC_W-1:0];
                CFG_OFFSET_X:     off_x_reg   <= cfg_data[OFF_W-1:0];
                CFG_OFFSET_Y:     off_y_reg   <= cfg_data[OFF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (src_w_reg == '0)
        begin
            src_w_eff = SRC_W'(1);
        end
        else if (src_w_reg > SRC_W_TOP)
        begin
            src_w_eff = SRC_W_TOP;
        end
        else
        begin
            src_w_eff = src_w_reg;
        end
    end

    // advance the raster position after each blit beat
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.capture && item.req_type == REQ_BLIT)
        begin
            if (item.last_pixel)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if ((SRC_W'(col_reg) + SRC_W'(1)) >= src_w_eff)
            begin
                col_next = '0;
                if (row_reg < ROW_TOP)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= item.req_type;
            color_reg <= {item.red[CB-1:0], item.green[CB-1:0], item.blue[CB-1:0]};
            if (item.req_type == REQ_BLIT)
            begin
                dx_reg <= POS_W'(col_reg) + {{(POS_W-OFF_W){off_x_reg[OFF_W-1]}}, off_x_reg};
                dy_reg <= POS_W'(row_reg) + {{(POS_W-OFF_W){off_y_reg[OFF_W-1]}}, off_y_reg};
            end
            else
            begin
                dx_reg <= POS_W'(item.read_x);
                dy_reg <= POS_W'(item.read_y);
            end
        end
    end

    assign eff_w = (POS_W'(frame_w_reg) > MW) ? MW : POS_W'(frame_w_reg);
    assign eff_h = (POS_W'(frame_h_reg) > MH) ? MH : POS_W'(frame_h_reg);

    assign pos_ok = !dx_reg[POS_W-1] && !dy_reg[POS_W-1] && (dx_reg < eff_w) && (dy_reg < eff_h);
    assign place_addr = AW'(32'(dy_reg) * 32'(MAX_WIDTH) + 32'(dx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            inside_reg <= pos_ok;
            addr_reg   <= place_addr;
        end
    end

    assign sweep_done = (sweep_cnt_reg == AW'(LAST_PIX));

    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (cmd.sweep)
        begin
            sweep_cnt_next = sweep_done ? '0 : sweep_cnt_reg + AW'(1);
        end
    end

    assign blit_hit = (kind_reg == REQ_BLIT) && inside_reg && !mask_q;
    assign mask_we  = cmd.sweep || (cmd.finish && blit_hit);
    assign mask_wa  = cmd.sweep ? sweep_cnt_reg : addr_reg;
    assign mask_wd  = !cmd.sweep;
    assign color_we = cmd.finish && blit_hit;

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_wa] <= mask_wd;
        end
        if (cmd.place)
        begin
            mask_q <= mask_mem[place_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[addr_reg] <= color_reg;
        end
        if (cmd.place)
        begin
            color_q <= color_mem[place_addr];
        end
    end

    // drop the stored color unless the pixel is in frame and written
    assign hit_read = inside_reg && mask_q;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_written_reg <= hit_read;
            rsp_red_reg     <= hit_read ? CHAN_W'(color_q[3*CB-1:2*CB]) : '0;
            rsp_green_reg   <= hit_read ? CHAN_W'(color_q[2*CB-1:CB]) : '0;
            rsp_blue_reg    <= hit_read ? CHAN_W'(color_q[CB-1:0]) : '0;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.sweep_done = sweep_done;

    assign pixel_written = rsp_written_reg;
    assign out_red       = rsp_red_reg;
    assign out_green     = rsp_green_reg;
    assign out_blue      = rsp_blue_reg;

endmodule

// ===== sv/clipped_write_once_blitter.sv =====
// Top level of the clipped write-once blitter: controller, datapath and channel hookup.
// A blit beat or a read beat passes through accept, clip and memory read, and decide; the
// request channel is ready again in the cycle after the decide, so no further blit or read
// is taken until the previous one has been decided.
// A read result sits in an output register until taken, and the next request is accepted
// meanwhile; a further read waits in its decide cycle while that register is full. A clear
// beat sweeps all MAX_WIDTH*MAX_HEIGHT mask entries (65536 by default) one entry per cycle,
// and the same sweep runs right after reset; no request is taken during a sweep,
// while configuration writes are taken at any time. An unknown request type is accepted
// and ignored.
module clipped_write_once_blitter import cwob_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cwob_req_if.sink    req,
    cwob_rsp_if.source  rsp,
    cwob_cfg_if.sink    cfg
);

    cwob_cmd_t  cmd;
    cwob_stat_t stat;
    req_item_t  item;
    logic       cfg_we;

    assign item.req_type   = req.req_type;
    assign item.red        = req.red;
    assign item.green      = req.green;
    assign item.blue       = req.blue;
    assign item.last_pixel = req.last_pixel;
    assign item.read_x     = req.read_x;
    assign item.read_y     = req.read_y;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    cwob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_type   (req.req_type),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cwob_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .pixel_written (rsp.pixel_written),
        .out_red       (rsp.out_red),
        .out_green     (rsp.out_green),
        .out_blue      (rsp.out_blue)
    );

    // a result is loaded only into a free or draining output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp.valid || rsp.ready))
        else $error("result loaded over a pending beat");

    // a pixel write never collides with the mask sweep
    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.finish && cmd.sweep))
        else $error("pixel write during mask sweep");

    // a read beat is clipped and looked up in the next cycle
    a_read_places: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_READ) |=> cmd.place)
        else $error("read beat not followed by lookup");

    // a clear beat starts the sweep right away and holds off requests
    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_CLEAR) |=> (cmd.sweep && !req.ready))
        else $error("clear beat did not start the sweep");

endmodule

// ===== tb/clipped_write_once_blitter_tb.sv =====
// Self-checking testbench for the clipped write-once blitter: directed cases, then random traffic.
module clipped_write_once_blitter_tb;
    import cwob_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXELS      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 10;
    localparam int CLIMB_ROWS  = 40;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic              written;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_read_t;

    logic clk;
    logic rst_n;

    cwob_req_if req_bus ();
    cwob_rsp_if rsp_bus ();
    cwob_cfg_if cfg_bus ();

    clipped_write_once_blitter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // Shadow of the block's registers, counters and frame contents.
    logic [FRAME_W-1:0]      frame_w_cfg;
    logic [FRAME_W-1:0]      frame_h_cfg;
    logic [SRC_W-1:0]        src_w_cfg;
    logic signed [OFF_W-1:0] off_x_cfg;
    logic signed [OFF_W-1:0] off_y_cfg;
    logic [COL_W-1:0]        src_col;
    logic [ROW_W-1:0]        src_row;
    bit                      mask_bits [PIXELS];
    logic [3*CHAN_W-1:0]     frame_colors [PIXELS];
    bit                      color_known [PIXELS];
    int                      known_addrs [$];

    pixel_read_t expected_reads [$];

    int fail_count;
    int cycle_count;
    bit idling;
    int rsp_hold;
    int rsp_stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        if (!idling)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic void place_pixel(input req_item_t it);
        int fw, fh, sw, dx, dy, addr;
        fw = int'(frame_w_cfg);
        fh = int'(frame_h_cfg);
        if (fw > DEF_MAX_WIDTH)
            fw = DEF_MAX_WIDTH;
        if (fh > DEF_MAX_HEIGHT)
            fh = DEF_MAX_HEIGHT;
        sw = int'(src_w_cfg);
        if (sw == 0)
            sw = 1;
        else if (sw > int'(SRC_W_TOP))
            sw = int'(SRC_W_TOP);
        dx = int'(src_col) + int'(off_x_cfg);
        dy = int'(src_row) + int'(off_y_cfg);
        if (dx >= 0 && dy >= 0 && dx < fw && dy < fh)
        begin
            addr = dy * DEF_MAX_WIDTH + dx;
            // first write wins until the next clear
            if (!mask_bits[addr])
            begin
                frame_colors[addr] = {it.red, it.green, it.blue};
                mask_bits[addr] = 1'b1;
                if (!color_known[addr])
                begin
                    color_known[addr] = 1'b1;
                    known_addrs.push_back(addr);
                end
            end
        end
        if (it.last_pixel)
        begin
            src_col = '0;
            src_row = '0;
        end
        else if (int'(src_col) + 1 >= sw)
        begin
            src_col = '0;
            if (src_row != ROW_TOP)
                src_row = src_row + ROW_W'(1);
        end
        else
        begin
            src_col = src_col + COL_W'(1);
        end
    endfunction

    function automatic pixel_read_t lookup_pixel(input req_item_t it);
        pixel_read_t res;
        int fw, fh, addr;
        res = '0;
        fw = int'(frame_w_cfg);
        fh = int'(frame_h_cfg);
        if (fw > DEF_MAX_WIDTH)
            fw = DEF_MAX_WIDTH;
        if (fh > DEF_MAX_HEIGHT)
            fh = DEF_MAX_HEIGHT;
        if (int'(it.read_x) < fw && int'(it.read_y) < fh)
        begin
            addr = int'(it.read_y) * DEF_MAX_WIDTH + int'(it.read_x);
            if (mask_bits[addr])
                res = {1'b1, frame_colors[addr]};
        end
        return res;
    endfunction

    function automatic void advance_frame(input req_item_t it);
        case (it.req_type)
            REQ_BLIT:  place_pixel(it);
            REQ_CLEAR: foreach (mask_bits[i]) mask_bits[i] = 1'b0;
            REQ_READ:  expected_reads.push_back(lookup_pixel(it));
            default: ;
        endcase
    endfunction

    function automatic req_item_t noise_item(input logic [REQ_W-1:0] kind);
        req_item_t it;
        it.req_type   = kind;
        it.red        = CHAN_W'($urandom_range(0, 255));
        it.green      = CHAN_W'($urandom_range(0, 255));
        it.blue       = CHAN_W'($urandom_range(0, 255));
        it.last_pixel = 1'($urandom_range(0, 1));
        it.read_x     = COORD_W'($urandom_range(0, 255));
        it.read_y     = COORD_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic req_item_t blit_item(input int r, input int g, input int b,
                                            input bit last);
        req_item_t it;
        it = noise_item(REQ_BLIT);
        it.red        = CHAN_W'(r);
        it.green      = CHAN_W'(g);
        it.blue       = CHAN_W'(b);
        it.last_pixel = last;
        return it;
    endfunction

    function automatic req_item_t read_item(input int x, input int y);
        req_item_t it;
        it = noise_item(REQ_READ);
        it.read_x = COORD_W'(x);
        it.read_y = COORD_W'(y);
        return it;
    endfunction

    // Read back only pixels whose color has been stored at some point.
    function automatic req_item_t read_any();
        int addr;
        addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        return read_item(addr % DEF_MAX_WIDTH, addr / DEF_MAX_WIDTH);
    endfunction

    // Entered and left at a falling edge; valid stays high into the next beat.
    task automatic send_req(input req_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= it.req_type;
        req_bus.red        <= it.red;
        req_bus.green      <= it.green;
        req_bus.blue       <= it.blue;
        req_bus.last_pixel <= it.last_pixel;
        req_bus.read_x     <= it.read_x;
        req_bus.read_y     <= it.read_y;
        do
            @(posedge clk);
        while (!req_bus.ready);
        advance_frame(it);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_FRAME_WIDTH:  frame_w_cfg = FRAME_W'(value);
            CFG_FRAME_HEIGHT: frame_h_cfg = FRAME_W'(value);
            CFG_SOURCE_WIDTH: src_w_cfg   = SRC_W'(value);
            CFG_OFFSET_X:     off_x_cfg   = OFF_W'(value);
            CFG_OFFSET_Y:     off_y_cfg   = OFF_W'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_frame_setup(input int fw, input int fh, input int sw,
                                     input int ox, input int oy);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
    endtask

    // Drop valid, wait for every read result, then let a trailing blit finish.
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // A read behind the clear is held until the sweep is over.
    task automatic send_clear();
        send_req(noise_item(REQ_CLEAR));
        send_req(read_any());
    endtask

    task automatic test_reset_defaults();
        // source width 1 out of reset: each pixel goes one row down
        send_req(blit_item(255, 0, 0, 1'b0));
        send_req(blit_item(0, 255, 0, 1'b0));
        send_req(blit_item(0, 0, 255, 1'b1));
        send_req(blit_item(1, 2, 3, 1'b1));
        send_req(read_item(0, 0));
        send_req(read_item(0, 2));
        send_req(blit_item(255, 255, 255, 1'b1) ^ {REQ_UNKNOWN, 41'd0});
        send_req(read_item(0, 1));
        wait_idle();
    endtask

    task automatic test_clip_and_first_write();
        write_frame_setup(256, 256, 4, -2, 5);
        send_req(blit_item(255, 255, 255, 1'b0));
        send_req(blit_item(0, 0, 0, 1'b0));
        send_req(blit_item(17, 34, 51, 1'b0));
        send_req(blit_item(255, 0, 255, 1'b0));
        send_req(blit_item(9, 9, 9, 1'b0));
        send_req(blit_item(8, 8, 8, 1'b1));
        send_req(read_item(0, 5));
        send_req(read_item(1, 5));
        // same placement again: both pixels are taken already
        send_req(blit_item(1, 1, 1, 1'b0));
        send_req(blit_item(2, 2, 2, 1'b0));
        send_req(blit_item(3, 3, 3, 1'b0));
        send_req(blit_item(4, 4, 4, 1'b1));
        send_req(read_item(0, 5));
        wait_idle();
        write_frame_setup(256, 256, 1024, 255, 255);
        send_req(blit_item(255, 255, 255, 1'b1));
        send_req(read_item(255, 255));
        wait_idle();
    endtask

    task automatic test_frame_bounds();
        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 1);
        send_req(read_item(255, 255));
        send_req(read_item(0, 0));
        send_req(read_item(0, 5));
        wait_idle();
    endtask

    task automatic test_clear();
        write_frame_setup(256, 256, 1, 0, 0);
        send_req(noise_item(REQ_CLEAR));
        send_req(read_item(0, 0));
        send_req(blit_item(77, 88, 99, 1'b1));
        send_req(read_item(0, 0));
        wait_idle();
    endtask

    task automatic test_row_advance();
        idling = 1'b0;
        // step the row counter down with every pixel clipped above the frame
        write_frame_setup(256, 256, 1, 0, -CLIMB_ROWS);
        for (int p = 0; p < CLIMB_ROWS; p++)
            send_req(blit_item($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), 1'b0));
        send_clear();
        wait_idle();
        write_reg(CFG_OFFSET_Y, 0);
        // the row counter kept its place, so these land below the top rows
        for (int p = 0; p < 3; p++)
            send_req(blit_item(200, 100, 50, 1'b0));
        send_req(read_item(0, 0));
        send_req(read_item(0, 1));
        send_req(read_item(0, 2));
        send_req(read_item(0, CLIMB_ROWS));
        send_req(read_item(0, CLIMB_ROWS + 2));
        send_req(blit_item(11, 22, 33, 1'b1));
        send_req(blit_item(44, 55, 66, 1'b1));
        send_req(read_item(0, 0));
        wait_idle();
        idling = 1'b1;
    endtask

    task automatic test_output_backpressure();
        idling = 1'b0;
        rsp_hold = 300;
        for (int p = 0; p < 16; p++)
            send_req(read_any());
        wait_idle();
        idling = 1'b1;
    endtask

    task automatic run_phase(input int fw, input int fh, input int sw, input int ox,
                             input int oy, input int n_items, input bit clear_first);
        int sent, roll, len;
        wait_idle();
        write_frame_setup(fw, fh, sw, ox, oy);
        if (clear_first)
            send_clear();
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                if (roll < 2)
                    len = sw + $urandom_range(0, 6);
                else if (roll < 8)
                    len = $urandom_range(40, 120);
                else
                    len = $urandom_range(1, 24);
                // mostly whole images; a few end without the last flag
                for (int p = 0; p < len; p++)
                    send_req(blit_item($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255),
                                       (p == len - 1) && ($urandom_range(0, 7) != 0)));
                sent += len;
            end
            else if (roll < 94)
            begin
                send_req(read_any());
                sent++;
            end
            else if (roll < 97)
            begin
                send_req(noise_item(REQ_UNKNOWN));
            end
            else
            begin
                req_bus.valid <= 1'b0;
                do
                    @(negedge clk);
                while (expected_reads.size() != 0);
            end
        end
    endtask

    task automatic test_random_traffic();
        int fw, fh, sw;
        run_phase(256, 256, 16, 0, 0, 100, 1'b0);
        run_phase(200, 120, 37, -5, 10, 90, 1'b1);
        run_phase(256, 256, 1024, -20, 3, 60, 1'b0);
        run_phase(1, 1, 1, 0, 0, 40, 1'b0);
        run_phase(256, 256, 7, -1024, 1023, 30, 1'b0);
        run_phase(64, 256, 1, 1023, -1024, 30, 1'b0);
        for (int k = 0; k < 4; k++)
        begin
            idling = ($urandom_range(0, 3) != 0);
            fw = $urandom_range(1, 256);
            fh = $urandom_range(1, 256);
            sw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 40);
            run_phase(fw, fh, sw, int'($urandom_range(0, fw + 19)) - 20,
                      int'($urandom_range(0, fh + 19)) - 20, 90, k == 2);
        end
        idling = 1'b1;
    endtask

    // Result ready: a long hold on request, random short and long stalls otherwise.
    initial
    begin
        rsp_bus.ready = 1'b0;
        rsp_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_hold--;
            end
            else if (rsp_stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rsp_stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_read_t got;
        pixel_read_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = {rsp_bus.pixel_written, rsp_bus.out_red, rsp_bus.out_green,
                   rsp_bus.out_blue};
            if (expected_reads.size() == 0)
            begin
                $display("%0t: unexpected read result written=%0b rgb=%02h%02h%02h", $time,
                         got.written, got.red, got.green, got.blue);
                fail_count++;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (got !== want)
                begin
                    $display("%0t: read mismatch exp %0b %02h%02h%02h got %0b %02h%02h%02h",
                             $time, want.written, want.red, want.green, want.blue,
                             got.written, got.red, got.green, got.blue);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = REQ_BLIT;
        req_bus.red        = '0;
        req_bus.green      = '0;
        req_bus.blue       = '0;
        req_bus.last_pixel = 1'b0;
        req_bus.read_x     = '0;
        req_bus.read_y     = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_FRAME_WIDTH;
        cfg_bus.data  = '0;
        fail_count = 0;
        idling = 1'b1;
        rsp_hold = 0;
        frame_w_cfg = RST_FRAME_WIDTH;
        frame_h_cfg = RST_FRAME_HEIGHT;
        src_w_cfg   = RST_SOURCE_WIDTH;
        off_x_cfg   = '0;
        off_y_cfg   = '0;
        src_col     = '0;
        src_row     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_clip_and_first_write();
        test_frame_bounds();
        test_clear();
        test_row_advance();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
